@@ sv/parabolic_peak_interpolator_core_defines.svh @@
// Assertion macros shared by the peak interpolator RTL.
// Included by the controller and the datapath; relies on clk and rst_n in scope.
`ifndef PARABOLIC_PEAK_INTERPOLATOR_CORE_DEFINES_SVH
`define PARABOLIC_PEAK_INTERPOLATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PPI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppi assertion failed");
`define PPI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppi assertion failed");
`else
`define PPI_ASSERT_IMP(lbl, ante, cons)
`define PPI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/ppi_pkg.sv @@
// Shared types and constants for the parabolic peak interpolator.
// No dependencies; imported by the controller, datapath and top level.
package ppi_pkg;

    // Default configuration
    localparam int MAX_LEN_DEF     = 4096;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;

    // Integer part of the position and width of the reported index
    localparam int IDX_W = 12;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FLAT     = 2'd1,
        ST_SHORT    = 2'd2,
        ST_OVERFLOW = 2'd3
    } ppi_status_t;

    // Controller states, one-hot
    typedef enum logic [3:0] {
        S_ACCUM  = 4'b0001,
        S_SETUP  = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_FINISH = 4'b1000
    } ppi_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // sample item taken this cycle
        logic setup;     // form numerator/denominator, load divider
        logic div_step;  // one quotient bit
        logic out_load;  // load result register, clear the run
    } ppi_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic skip_div;  // short run or flat denominator
        logic div_done;  // current divide step is the final one
        logic out_free;  // result register can take a new result
    } ppi_sts_t;

endpackage

@@ sv/ppi_datapath.sv @@
// Datapath of the peak interpolator: run tracking, bit-serial divider, result register.
// Depends on ppi_pkg and the shared assertion macros.
`include "parabolic_peak_interpolator_core_defines.svh"

module ppi_datapath
    import ppi_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ppi_cmd_t                      cmd,
    output ppi_sts_t                      sts,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [IDX_W+FRAC_BITS-1:0]    peak_pos,
    output logic [IDX_W-1:0]              peak_index,
    output logic signed [SAMPLE_BITS-1:0] peak_value,
    output logic [1:0]                    status
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int POS_W  = IDX_W + FRAC_BITS;
    localparam int NUM_W  = SAMPLE_BITS + 1;
    localparam int DEN_W  = SAMPLE_BITS + 3;
    localparam int DVD_W  = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int STEP_W = $clog2(DVD_W + 1);
    localparam int SUM_W  = CNT_W + DVD_W + 2;

    // Run tracking state
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              bidx_reg, bidx_next;
    logic                          pend_reg, pend_next;
    logic                          ovf_reg, ovf_next;
    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic signed [SAMPLE_BITS-1:0] best_reg, best_next;
    logic signed [SAMPLE_BITS-1:0] left_reg, left_next;
    logic signed [SAMPLE_BITS-1:0] right_reg, right_next;

    // Divider state
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DEN_W-1:0]  ad_reg, ad_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic              flat_reg, flat_next;
    logic              short_reg, short_next;

    // Result register
    logic              ovalid_reg, ovalid_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    ppi_status_t       status_reg, status_next;

    // Combinational helpers
    logic                    cand;
    logic signed [DEN_W-1:0] best_x, left_x, right_x, den_s;
    logic signed [NUM_W-1:0] num_s;
    logic [NUM_W-1:0]        an_full;
    logic [DEN_W-1:0]        ad_w;
    logic [DVD_W-1:0]        dvd_init;
    logic                    short_now, flat_now;
    logic [DEN_W:0]          trial;
    logic                    ge;
    logic signed [SUM_W-1:0] base, q_x, p_sum;
    logic [POS_W-1:0]        pos_clamped;
    ppi_status_t             status_w;

    // Interior candidate: not the first, last, or truncation-point sample
    assign cand = !last && (count_reg >= CNT_W'(1)) && (count_reg < CNT_W'(MAX_LEN - 1)) &&
                  ((count_reg == CNT_W'(1)) || (sample > best_reg));

    // Numerator and doubled denominator of the vertex offset
    assign best_x  = {{3{best_reg[SAMPLE_BITS-1]}}, best_reg};
    assign left_x  = {{3{left_reg[SAMPLE_BITS-1]}}, left_reg};
    assign right_x = {{3{right_reg[SAMPLE_BITS-1]}}, right_reg};
    assign den_s   = (best_x <<< 2) - (left_x <<< 1) - (right_x <<< 1);
    assign num_s   = {right_reg[SAMPLE_BITS-1], right_reg} - {left_reg[SAMPLE_BITS-1], left_reg};
    assign an_full = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
    assign ad_w    = den_s[DEN_W-1] ? DEN_W'(-den_s) : DEN_W'(den_s);
    // Rounded division: add half the divisor to the scaled numerator
    assign dvd_init = {1'b0, an_full[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}} +
                      DVD_W'(ad_w >> 1);
    assign short_now = count_reg < CNT_W'(3);
    assign flat_now  = den_s == '0;

    // One restoring divide step
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, ad_reg};

    // Final position: index plus signed fraction, clamped
    assign base  = $signed({{(SUM_W-CNT_W-FRAC_BITS){1'b0}}, bidx_reg, {FRAC_BITS{1'b0}}});
    assign q_x   = $signed({{(SUM_W-DVD_W){1'b0}}, dvd_reg});
    assign p_sum = flat_reg ? base : (neg_reg ? base - q_x : base + q_x);
    assign pos_clamped = p_sum[SUM_W-1] ? '0 :
                         ((|p_sum[SUM_W-2:POS_W]) ? '1 : p_sum[POS_W-1:0]);

    always_comb
    begin
        if (ovf_reg)
            status_w = ST_OVERFLOW;
        else if (short_reg)
            status_w = ST_SHORT;
        else if (flat_reg)
            status_w = ST_FLAT;
        else
            status_w = ST_OK;
    end

    // Next-state logic
    always_comb
    begin
        count_next  = count_reg;
        bidx_next   = bidx_reg;
        pend_next   = pend_reg;
        ovf_next    = ovf_reg;
        prev_next   = prev_reg;
        best_next   = best_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        dvd_next    = dvd_reg;
        ad_next     = ad_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        neg_next    = neg_reg;
        flat_next   = flat_reg;
        short_next  = short_reg;
        ovalid_next = ovalid_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        status_next = status_reg;

        // Sample accumulation
        if (cmd.accept)
        begin
            if (count_reg >= CNT_W'(MAX_LEN))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                if (pend_reg)
                begin
                    right_next = sample;
                    pend_next  = 1'b0;
                end
                if (cand)
                begin
                    best_next = sample;
                    bidx_next = count_reg;
                    left_next = prev_reg;
                    pend_next = 1'b1;
                end
                prev_next  = sample;
                count_next = count_reg + CNT_W'(1);
            end
        end

        // Divider load
        if (cmd.setup)
        begin
            dvd_next   = dvd_init;
            ad_next    = ad_w;
            rem_next   = '0;
            step_next  = STEP_W'(DVD_W);
            neg_next   = num_s[NUM_W-1] ^ den_s[DEN_W-1];
            flat_next  = flat_now;
            short_next = short_now;
        end

        // Divider iteration
        if (cmd.div_step)
        begin
            rem_next  = ge ? DEN_W'(trial - {1'b0, ad_reg}) : trial[DEN_W-1:0];
            dvd_next  = {dvd_reg[DVD_W-2:0], ge};
            step_next = step_reg - STEP_W'(1);
        end

        // Result register handshake
        if (m_tready)
            ovalid_next = 1'b0;
        if (cmd.out_load)
        begin
            ovalid_next = 1'b1;
            pos_next    = short_reg ? '0 : pos_clamped;
            idx_next    = short_reg ? '0 : IDX_W'(bidx_reg);
            val_next    = short_reg ? '0 : best_reg;
            status_next = status_w;
            count_next  = '0;
            bidx_next   = '0;
            pend_next   = 1'b0;
            ovf_next    = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            bidx_reg   <= '0;
            pend_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            bidx_reg   <= bidx_next;
            pend_reg   <= pend_next;
            ovf_reg    <= ovf_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prev_reg   <= prev_next;
        best_reg   <= best_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        dvd_reg    <= dvd_next;
        ad_reg     <= ad_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        flat_reg   <= flat_next;
        short_reg  <= short_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        status_reg <= status_next;
    end

    // Status to controller
    assign sts.skip_div = short_now | flat_now;
    assign sts.div_done = step_reg == STEP_W'(1);
    assign sts.out_free = !ovalid_reg || m_tready;

    assign m_tvalid   = ovalid_reg;
    assign peak_pos   = pos_reg;
    assign peak_index = idx_reg;
    assign peak_value = val_reg;
    assign status     = status_reg;

    // Checks
    `PPI_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(MAX_LEN))
    `PPI_ASSERT_IMP(a_pend_follows_best, pend_reg, count_reg == (bidx_reg + CNT_W'(1)))
    `PPI_ASSERT_IMP(a_load_when_free, cmd.out_load, !ovalid_reg || m_tready)

endmodule

@@ sv/ppi_ctrl.sv @@
// Controller of the peak interpolator: sequences accumulate, setup, divide, finish.
// Depends on ppi_pkg and the shared assertion macros.
`include "parabolic_peak_interpolator_core_defines.svh"

module ppi_ctrl
    import ppi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    input  ppi_sts_t sts,
    output ppi_cmd_t cmd
);

    ppi_state_t state_reg, state_next;

    // Commands
    assign s_tready     = state_reg == S_ACCUM;
    assign cmd.accept   = s_tvalid && (state_reg == S_ACCUM);
    assign cmd.setup    = state_reg == S_SETUP;
    assign cmd.div_step = state_reg == S_DIVIDE;
    assign cmd.out_load = (state_reg == S_FINISH) && sts.out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_ACCUM:
            begin
                if (cmd.accept && s_tlast)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                state_next = sts.skip_div ? S_FINISH : S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (sts.div_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                    state_next = S_ACCUM;
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_ACCUM;
        else
            state_reg <= state_next;
    end

    // Checks
    `PPI_ASSERT_NXT(a_last_to_setup, cmd.accept && s_tlast, state_reg == S_SETUP)
    `PPI_ASSERT_NXT(a_div_to_finish, (state_reg == S_DIVIDE) && sts.div_done,
        state_reg == S_FINISH)
    `PPI_ASSERT_NXT(a_finish_to_accum, (state_reg == S_FINISH) && sts.out_free,
        state_reg == S_ACCUM)

endmodule

@@ sv/parabolic_peak_interpolator_core.sv @@
// Parabolic peak interpolator, top level: controller plus datapath.
// Depends on ppi_pkg, ppi_ctrl and ppi_datapath.
//
// Samples of a run stream in one per cycle on the s_ side while the block is
// accepting, the final one with s_tlast. Once the last sample is taken the block
// stops accepting through a setup state, then its one-bit-per-cycle restoring
// divider, which is skipped for a short run or a flat denominator, then a finish
// state that loads the result register. The result waits in its register on the
// m_ side while the next run streams in; beyond the setup, divide and finish
// states the block only stalls at a run end if the previous result is still
// untaken.

module parabolic_peak_interpolator_core
    import ppi_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // sample[SAMPLE_BITS-1:0], zero padding above
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // peak_pos (12+FRAC_BITS), peak_index (12), peak_value (SAMPLE_BITS),
    // status (2), zero padding above
    output logic [((IDX_W+FRAC_BITS+IDX_W+SAMPLE_BITS+2+7)/8)*8-1:0] m_tdata
);

    localparam int POS_W = IDX_W + FRAC_BITS;
    localparam int M_W   = ((POS_W + IDX_W + SAMPLE_BITS + 2 + 7) / 8) * 8;

    ppi_cmd_t                      cmd;
    ppi_sts_t                      sts;
    logic [POS_W-1:0]              peak_pos;
    logic [IDX_W-1:0]              peak_index;
    logic signed [SAMPLE_BITS-1:0] peak_value;
    logic [1:0]                    status;

    ppi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ppi_datapath #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .sample     ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .last       (s_tlast),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .peak_pos   (peak_pos),
        .peak_index (peak_index),
        .peak_value (peak_value),
        .status     (status)
    );

    // Pack result fields, lowest field first
    assign m_tdata = M_W'({status, peak_value, peak_index, peak_pos});

endmodule
